/* hdl/assert_macros.svh */
// Assertion macros shared by the vector ALU RTL.
// Defining SYNTH removes every assertion body; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VAU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property violated");
`define VAU_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define VAU_ASSERT(label, clk, rst, prop)
`define VAU_NEVER(label, clk, rst, expr)
`endif
`endif

/* hdl/vau_pkg.sv */
// Types, constants and the saturation helper of the fixed-point vector ALU.
// Depends on nothing; every RTL module imports it.
package vau_pkg;

  localparam int Q_W          = 32;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_DIMS     = 4;
  localparam int LANES        = 4;
  localparam int CROSS_N      = 3;
  localparam int PROD_W       = 2 * Q_W;
  localparam int PAIR_W       = PROD_W + 1;
  localparam int SUM_W        = PROD_W + 2;
  localparam int ROOT_W       = Q_W;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int LEN_W        = ROOT_W + 1;
  localparam int DIV_STEPS    = Q_W + FRAC_BITS;
  localparam int FRONT_STAGES = 3;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + DIV_STEPS + 1;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] Q_MAX_W = SUM_W'(Q_MAX);
  localparam logic signed [SUM_W-1:0] Q_MIN_W = SUM_W'(Q_MIN);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_DOT    = 3'd4,
    CMD_LENGTH = 3'd5,
    CMD_NORM   = 3'd6,
    CMD_CROSS  = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [LANES-1:0]     en;
    q_t   [LANES-1:0]     a;
    q_t   [LANES-1:0]     b;
    q_t   [LANES-1:0]     res;
    logic                 sat;
    logic                 last;
  } item_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } clamp_t;

  function automatic clamp_t sat_clamp(input logic signed [SUM_W-1:0] v);
    clamp_t c;
    if (v > Q_MAX_W) begin
      c.val = Q_MAX;
      c.sat = 1'b1;
    end else if (v < Q_MIN_W) begin
      c.val = Q_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = v[Q_W-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

/* hdl/fixed_point_vector_alu_top.sv */
// Fixed-point vector ALU: Q16.16 vectors of 2 to 4 components, one result per transaction.
// The path from start to done runs through 3 front stages, 32 square-root stages,
// 48 divider stages and the output register; it is the same for every command.
// Throughput is one transaction per cycle; busy is always low and the receiver cannot stall.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
`include "assert_macros.svh"
module fixed_point_vector_alu_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          command,
  input  logic [2:0]          dims,
  input  vau_pkg::q_t         a_x,
  input  vau_pkg::q_t         a_y,
  input  vau_pkg::q_t         a_z,
  input  vau_pkg::q_t         a_w,
  input  vau_pkg::q_t         b_x,
  input  vau_pkg::q_t         b_y,
  input  vau_pkg::q_t         b_z,
  input  vau_pkg::q_t         b_w,
  input  logic                batch_end,
  output logic                done,
  output vau_pkg::q_t         r_x,
  output vau_pkg::q_t         r_y,
  output vau_pkg::q_t         r_z,
  output vau_pkg::q_t         r_w,
  output logic                saturated,
  output logic                divide_by_zero,
  output logic                result_last
);
  import vau_pkg::*;

  q_t [LANES-1:0] a;
  q_t [LANES-1:0] b;
  q_t [LANES-1:0] res;

  logic                 f_vld;
  item_t                f_item;
  logic [SUM_W-2:0]     f_sq;
  logic                 s_vld;
  item_t                s_item;
  logic [LEN_W-1:0]     s_len;

  assign busy = 1'b0;
  assign a = {a_w, a_z, a_y, a_x};
  assign b = {b_w, b_z, b_y, b_x};

  vau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && !busy),
    .cmd      (cmd_t'(command)),
    .dims     (dims),
    .a        (a),
    .b        (b),
    .last     (batch_end),
    .out_vld  (f_vld),
    .out_item (f_item),
    .sq       (f_sq)
  );

  vau_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_item  (f_item),
    .sq       (f_sq),
    .out_vld  (s_vld),
    .out_item (s_item),
    .len      (s_len)
  );

  vau_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s_vld),
    .in_item (s_item),
    .len     (s_len),
    .out_vld (done),
    .res     (res),
    .sat     (saturated),
    .dz      (divide_by_zero),
    .last    (result_last)
  );

  assign r_x = res[0];
  assign r_y = res[1];
  assign r_z = res[2];
  assign r_w = res[3];

  `VAU_ASSERT(a_latency, clk, rst, start |-> ##LATENCY done)
  `VAU_ASSERT(a_no_spurious, clk, rst, done |-> $past(start, LATENCY))
  `VAU_ASSERT(a_last_order, clk, rst, done |-> result_last == $past(batch_end, LATENCY))
  `VAU_ASSERT(a_dz_cmd, clk, rst, (done && divide_by_zero) |-> ($past(command, LATENCY) == CMD_DIV || $past(command, LATENCY) == CMD_NORM))

endmodule

/* hdl/vau_front.sv */
// Front end of the vector ALU: products, element-wise results, dot sums and cross terms.
// Three register stages; uses vau_pkg.
module vau_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  vau_pkg::cmd_t                       cmd,
  input  logic [2:0]                          dims,
  input  vau_pkg::q_t [vau_pkg::LANES-1:0]    a,
  input  vau_pkg::q_t [vau_pkg::LANES-1:0]    b,
  input  logic                                last,
  output logic                                out_vld,
  output vau_pkg::item_t                      out_item,
  output logic [vau_pkg::SUM_W-2:0]           sq
);
  import vau_pkg::*;

  logic [2:0]              n;
  q_t [LANES-1:0]          x;
  q_t [LANES-1:0]          y;
  q_t [CROSS_N-1:0]        xc;
  q_t [CROSS_N-1:0]        yc;
  item_t                   item1_next;

  logic                    vld1;
  item_t                   item1;
  logic signed [PROD_W-1:0] p1 [LANES];
  logic signed [PROD_W-1:0] pc1 [CROSS_N];
  logic signed [Q_W:0]     as1 [LANES];

  clamp_t                  c;
  logic signed [PROD_W-1:0] pm [LANES];
  item_t                   item2_next;
  logic signed [PAIR_W-1:0] pr_next [2];
  logic signed [PAIR_W-1:0] cr_next [CROSS_N];

  logic                    vld2;
  item_t                   item2;
  logic signed [PAIR_W-1:0] pr [2];
  logic signed [PAIR_W-1:0] cr [CROSS_N];

  logic signed [SUM_W-1:0] s;
  clamp_t                  c3;
  item_t                   item3_next;

  always_comb begin
    n = dims;
    if (dims < 3'd2) begin
      n = 3'd2;
    end else if (dims > 3'(MAX_DIMS)) begin
      n = 3'(MAX_DIMS);
    end
    x = a;
    y = b;
    if (cmd == CMD_LENGTH || cmd == CMD_NORM) begin
      y = a;
    end
    if (cmd == CMD_CROSS) begin
      x[0] = a[1]; y[0] = b[2];
      x[1] = a[2]; y[1] = b[0];
      x[2] = a[0]; y[2] = b[1];
    end
    xc[0] = a[2]; yc[0] = b[1];
    xc[1] = a[0]; yc[1] = b[2];
    xc[2] = a[1]; yc[2] = b[0];
    item1_next.cmd  = cmd;
    item1_next.a    = a;
    item1_next.b    = b;
    item1_next.res  = '0;
    item1_next.sat  = 1'b0;
    item1_next.last = last;
    for (int i = 0; i < LANES; i++) begin
      item1_next.en[i] = 3'(i) < n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    item1 <= item1_next;
    for (int i = 0; i < LANES; i++) begin
      p1[i] <= $signed(x[i]) * $signed(y[i]);
      if (cmd == CMD_SUB) begin
        as1[i] <= (Q_W+1)'($signed(a[i])) - (Q_W+1)'($signed(b[i]));
      end else begin
        as1[i] <= (Q_W+1)'($signed(a[i])) + (Q_W+1)'($signed(b[i]));
      end
    end
    for (int k = 0; k < CROSS_N; k++) begin
      pc1[k] <= $signed(xc[k]) * $signed(yc[k]);
    end
  end

  always_comb begin
    item2_next = item1;
    for (int i = 0; i < LANES; i++) begin
      case (item1.cmd)
        CMD_ADD, CMD_SUB: c = sat_clamp(SUM_W'(as1[i]));
        CMD_MUL:          c = sat_clamp(SUM_W'(p1[i]) >>> FRAC_BITS);
        default:          c = '0;
      endcase
      item2_next.res[i] = item1.en[i] ? c.val : '0;
      item2_next.sat    = item2_next.sat | (item1.en[i] & c.sat);
      pm[i] = item1.en[i] ? p1[i] : '0;
    end
    pr_next[0] = PAIR_W'(pm[0]) + PAIR_W'(pm[1]);
    pr_next[1] = PAIR_W'(pm[2]) + PAIR_W'(pm[3]);
    for (int k = 0; k < CROSS_N; k++) begin
      cr_next[k] = PAIR_W'(p1[k]) - PAIR_W'(pc1[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    item2 <= item2_next;
    pr    <= pr_next;
    cr    <= cr_next;
  end

  always_comb begin
    s = SUM_W'(pr[0]) + SUM_W'(pr[1]);
    item3_next = item2;
    c3 = '0;
    case (item2.cmd)
      CMD_DOT: begin
        c3 = sat_clamp(s >>> FRAC_BITS);
        item3_next.res[0] = c3.val;
        item3_next.sat    = c3.sat;
      end
      CMD_CROSS: begin
        for (int k = 0; k < CROSS_N; k++) begin
          c3 = sat_clamp(SUM_W'(cr[k]) >>> FRAC_BITS);
          item3_next.res[k] = c3.val;
          item3_next.sat    = item3_next.sat | c3.sat;
        end
      end
      default: begin
        item3_next = item2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld2;
    end
    out_item <= item3_next;
    sq       <= s[SUM_W-2:0];
  end

endmodule

/* hdl/vau_sqrt.sv */
// Pipelined integer square root of the sum of squares, one root bit per stage.
// Carries the transaction alongside; uses vau_pkg.
module vau_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  vau_pkg::item_t                 in_item,
  input  logic [vau_pkg::SUM_W-2:0]      sq,
  output logic                           out_vld,
  output vau_pkg::item_t                 out_item,
  output logic [vau_pkg::LEN_W-1:0]      len
);
  import vau_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0]  vld;
  logic [ROOT_W-1:0]  wide;
  item_t              item [ROOT_W];
  logic [REM_W-1:0]   rem  [ROOT_W];
  logic [ROOT_W-1:0]  root [ROOT_W];
  logic [RAD_W-1:0]   rad  [ROOT_W];

  logic [REM_W-1:0]   rem_next  [ROOT_W];
  logic [ROOT_W-1:0]  root_next [ROOT_W];
  logic [RAD_W-1:0]   rad_next  [ROOT_W];

  logic [REM_W-1:0]   s_rem;
  logic [ROOT_W-1:0]  s_root;
  logic [RAD_W-1:0]   s_rad;
  logic [REM_W+1:0]   t;
  logic [REM_W+1:0]   trial;
  logic               ge;

  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_rad  = sq[RAD_W-1:0];
      end else begin
        s_rem  = rem[k-1];
        s_root = root[k-1];
        s_rad  = rad[k-1];
      end
      t     = {s_rem, s_rad[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({s_root, 2'b01});
      ge    = t >= trial;
      rem_next[k]  = ge ? REM_W'(t - trial) : REM_W'(t);
      root_next[k] = {s_root[ROOT_W-2:0], ge};
      rad_next[k]  = s_rad << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ROOT_W-2:0], in_vld};
    end
    wide    <= {wide[ROOT_W-2:0], sq[RAD_W]};
    item[0] <= in_item;
    for (int k = 1; k < ROOT_W; k++) begin
      item[k] <= item[k-1];
    end
    rem  <= rem_next;
    root <= root_next;
    rad  <= rad_next;
  end

  assign out_vld  = vld[ROOT_W-1];
  assign out_item = item[ROOT_W-1];
  assign len      = wide[ROOT_W-1] ? (LEN_W'(1) << ROOT_W) : LEN_W'(root[ROOT_W-1]);

endmodule

/* hdl/vau_div.sv */
// Pipelined restoring divider for div and normalize, one quotient bit per stage,
// followed by the output register of the ALU; uses vau_pkg.
module vau_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  vau_pkg::item_t                    in_item,
  input  logic [vau_pkg::LEN_W-1:0]         len,
  output logic                              out_vld,
  output vau_pkg::q_t [vau_pkg::LANES-1:0]  res,
  output logic                              sat,
  output logic                              dz,
  output logic                              last
);
  import vau_pkg::*;

  typedef struct packed {
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] quo;
    logic [LEN_W-1:0]     rem;
    logic [LEN_W-1:0]     dmag;
    logic                 neg;
    logic                 zero;
    logic                 apos;
    logic                 aneg;
    logic                 act;
  } lane_t;

  localparam logic [DIV_STEPS-1:0] QLIM = DIV_STEPS'(1) << (Q_W - 1);

  function automatic lane_t div_step(input lane_t l);
    lane_t            o;
    logic [LEN_W:0]   t;
    logic             ge;
    o  = l;
    t  = {l.rem, l.num[DIV_STEPS-1]};
    ge = t >= {1'b0, l.dmag};
    o.rem = ge ? LEN_W'(t - {1'b0, l.dmag}) : t[LEN_W-1:0];
    o.num = l.num << 1;
    o.quo = {l.quo[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  logic [DIV_STEPS-1:0]  vld;
  item_t                 item [DIV_STEPS];
  lane_t [LANES-1:0]     ln [DIV_STEPS];
  lane_t [LANES-1:0]     ln_next [DIV_STEPS];

  item_t                 item0;
  lane_t [LANES-1:0]     ln0;
  logic signed [LEN_W:0] d;
  logic [Q_W-1:0]        amag;
  q_t                    av;

  item_t                 itf;
  lane_t                 lf;
  q_t   [LANES-1:0]      res_next;
  logic                  sat_next;
  logic                  dz_next;

  always_comb begin
    item0 = in_item;
    if (in_item.cmd == CMD_LENGTH) begin
      if (len > LEN_W'(Q_MAX)) begin
        item0.res[0] = Q_MAX;
        item0.sat    = 1'b1;
      end else begin
        item0.res[0] = len[Q_W-1:0];
      end
    end
    for (int i = 0; i < LANES; i++) begin
      av = in_item.a[i];
      if (in_item.cmd == CMD_NORM) begin
        d = $signed({1'b0, len});
      end else begin
        d = (LEN_W+1)'($signed(in_item.b[i]));
      end
      amag = av[Q_W-1] ? Q_W'(-av) : av;
      ln0[i].num  = DIV_STEPS'(amag) << FRAC_BITS;
      ln0[i].quo  = '0;
      ln0[i].rem  = '0;
      ln0[i].dmag = d[LEN_W] ? LEN_W'(-d) : d[LEN_W-1:0];
      ln0[i].neg  = av[Q_W-1] ^ d[LEN_W];
      ln0[i].zero = d == '0;
      ln0[i].apos = !av[Q_W-1] && av != '0;
      ln0[i].aneg = av[Q_W-1];
      ln0[i].act  = in_item.en[i] && (in_item.cmd == CMD_DIV || in_item.cmd == CMD_NORM);
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < LANES; i++) begin
        if (k == 0) begin
          ln_next[k][i] = div_step(ln0[i]);
        end else begin
          ln_next[k][i] = div_step(ln[k-1][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STEPS-2:0], in_vld};
    end
    item[0] <= item0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      item[k] <= item[k-1];
    end
    ln <= ln_next;
  end

  always_comb begin
    itf      = item[DIV_STEPS-1];
    sat_next = itf.sat;
    dz_next  = 1'b0;
    res_next = itf.res;
    for (int i = 0; i < LANES; i++) begin
      lf = ln[DIV_STEPS-1][i];
      if (lf.act) begin
        if (lf.zero) begin
          dz_next = 1'b1;
          res_next[i] = lf.apos ? Q_MAX : (lf.aneg ? Q_MIN : '0);
        end else if (lf.neg) begin
          if (lf.quo > QLIM) begin
            res_next[i] = Q_MIN;
            sat_next    = 1'b1;
          end else begin
            res_next[i] = -$signed(lf.quo[Q_W-1:0]);
          end
        end else begin
          if (lf.quo >= QLIM) begin
            res_next[i] = Q_MAX;
            sat_next    = 1'b1;
          end else begin
            res_next[i] = $signed(lf.quo[Q_W-1:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[DIV_STEPS-1];
    end
    res  <= res_next;
    sat  <= sat_next;
    dz   <= dz_next;
    last <= itf.last;
  end

endmodule

/* dv/vau_checker.sv */
// Checker for the fixed-point vector ALU: watches accepted commands and results,
// predicts each result from the operands and compares it field by field.
// Depends on vau_pkg for the command encoding and the component type.
module vau_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  dims,
  input  vau_pkg::q_t a_x, a_y, a_z, a_w,
  input  vau_pkg::q_t b_x, b_y, b_z, b_w,
  input  logic        batch_end,
  input  logic        done,
  input  vau_pkg::q_t r_x, r_y, r_z, r_w,
  input  logic        saturated,
  input  logic        divide_by_zero,
  input  logic        result_last,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import vau_pkg::*;

  typedef struct packed {
    q_t   x, y, z, w;
    logic sat, dz, last;
  } vau_result_t;

  vau_result_t expected_results[$];

  localparam longint QMAX64 = 64'sd2147483647;
  localparam longint QMIN64 = -64'sd2147483648;

  function automatic longint clamp_q(input longint v, inout logic sat);
    if (v > QMAX64) begin
      sat = 1'b1;
      return QMAX64;
    end
    if (v < QMIN64) begin
      sat = 1'b1;
      return QMIN64;
    end
    return v;
  endfunction

  function automatic longint q_div(input longint n, input longint d, inout logic sat,
                                   inout logic dz);
    if (d == 0) begin
      dz = 1'b1;
      return n > 0 ? QMAX64 : (n < 0 ? QMIN64 : 0);
    end
    return clamp_q((n * 65536) / d, sat);
  endfunction

  function automatic longint floor_sqrt(input logic [63:0] s);
    logic [63:0] root, trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if ({64'd0, trial} * {64'd0, trial} <= {64'd0, s}) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic vau_result_t predict_result(
      input logic [2:0] cmd, input logic [2:0] n_in, input q_t a [4], input q_t b [4],
      input logic last);
    vau_result_t res;
    longint r [4];
    longint av [4];
    longint bv [4];
    logic sat, dz, wide;
    int n;
    logic signed [127:0] acc;
    logic [64:0] sq_sum;
    longint len;
    sat = 0;
    dz = 0;
    wide = 0;
    acc = 0;
    sq_sum = 0;
    n = n_in < 2 ? 2 : (n_in > 4 ? 4 : n_in);
    for (int i = 0; i < 4; i++) begin
      r[i] = 0;
      av[i] = a[i];
      bv[i] = b[i];
    end
    case (cmd_t'(cmd))
      CMD_ADD: for (int i = 0; i < n; i++) r[i] = clamp_q(av[i] + bv[i], sat);
      CMD_SUB: for (int i = 0; i < n; i++) r[i] = clamp_q(av[i] - bv[i], sat);
      CMD_MUL: for (int i = 0; i < n; i++) r[i] = clamp_q((av[i] * bv[i]) >>> 16, sat);
      CMD_DIV: for (int i = 0; i < n; i++) r[i] = q_div(av[i], bv[i], sat, dz);
      CMD_DOT: begin
        for (int i = 0; i < n; i++) acc += 128'(av[i] * bv[i]);
        acc = acc >>> 16;
        if (acc > 128'(QMAX64)) begin
          sat = 1;
          r[0] = QMAX64;
        end else if (acc < 128'(QMIN64)) begin
          sat = 1;
          r[0] = QMIN64;
        end else r[0] = longint'(acc);
      end
      CMD_LENGTH, CMD_NORM: begin
        for (int i = 0; i < n; i++) sq_sum += 65'(64'(av[i] * av[i]));
        wide = sq_sum[64];
        len = wide ? 64'd1 << 32 : floor_sqrt(sq_sum[63:0]);
        if (cmd == CMD_LENGTH) r[0] = clamp_q(len, sat);
        else if (len == 0) dz = 1;
        else for (int i = 0; i < n; i++) r[i] = q_div(av[i], len, sat, dz);
      end
      default: begin
        r[0] = clamp_q((av[1] * bv[2] - av[2] * bv[1]) >>> 16, sat);
        r[1] = clamp_q((av[2] * bv[0] - av[0] * bv[2]) >>> 16, sat);
        r[2] = clamp_q((av[0] * bv[1] - av[1] * bv[0]) >>> 16, sat);
      end
    endcase
    res.x = r[0][31:0];
    res.y = r[1][31:0];
    res.z = r[2][31:0];
    res.w = r[3][31:0];
    res.sat = sat;
    res.dz = dz;
    res.last = last;
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    vau_result_t got, want;
    q_t av [4];
    q_t bv [4];
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (start && !busy) begin
        av = '{a_x, a_y, a_z, a_w};
        bv = '{b_x, b_y, b_z, b_w};
        expected_results.push_back(predict_result(command, dims, av, bv, batch_end));
      end
      if (done) begin
        got = '{r_x, r_y, r_z, r_w, saturated, divide_by_zero, result_last};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with no transaction pending");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: expected x=%h y=%h z=%h w=%h sat=%b dz=%b last=%b, got x=%h y=%h z=%h w=%h sat=%b dz=%b last=%b",
                       want.x, want.y, want.z, want.w, want.sat, want.dz, want.last,
                       got.x, got.y, got.z, got.w, got.sat, got.dz, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/testbench.sv */
// Top of the vector ALU testbench: makes clock, reset and commands, and gives the verdict.
// Depends on vau_pkg, vau_checker and the fixed_point_vector_alu_top RTL.
module testbench;
  import vau_pkg::*;

  localparam int NUM_RANDOM = 750;
  localparam int IDLE_LIMIT = 2000;

  logic       clk, rst, start, busy, batch_end, done;
  logic [2:0] command, dims;
  q_t         a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
  q_t         r_x, r_y, r_z, r_w;
  logic       saturated, divide_by_zero, result_last;
  int         fail_count, pending, result_count, idle_cycles, sent;

  fixed_point_vector_alu_top u_dut (.*);

  vau_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 0;
      3: return q_t'($urandom_range(0, 3)) << 16;
      4, 5: return q_t'($signed($urandom_range(0, 32'h3ffff) - 32'h20000)) << 4;
      6: return q_t'($signed($urandom_range(0, 32'h1ff) - 32'h100));
      default: return q_t'($urandom());
    endcase
  endfunction

  task automatic issue_command(input logic [2:0] cmd, input logic [2:0] n,
                               input q_t ax, ay, az, aw, bx, by, bz, bw);
    command <= cmd;
    dims <= n;
    a_x <= ax;
    a_y <= ay;
    a_z <= az;
    a_w <= aw;
    b_x <= bx;
    b_y <= by;
    b_z <= bz;
    b_w <= bw;
    batch_end <= 1'($urandom_range(0, 1));
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic issue_random();
    q_t zb;
    zb = $urandom_range(0, 5) == 0 ? q_t'(0) : rand_q();
    issue_command(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_q(), rand_q(),
                  rand_q(), rand_q(), rand_q(), zb, rand_q(), rand_q());
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int burst;
    sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_ADD;
    dims <= 3'd2;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} <= '0;
    batch_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_command(CMD_ADD, 3'd4, Q_MAX, Q_MIN, 1, -1, Q_MAX, Q_MIN, -1, 1);
    issue_command(CMD_SUB, 3'd4, Q_MAX, Q_MIN, 0, 5, Q_MIN, Q_MAX, 0, 5);
    issue_command(CMD_MUL, 3'd4, Q_MAX, Q_MIN, -1, 32'h10000, Q_MAX, Q_MIN, 1, -3);
    issue_command(CMD_DIV, 3'd4, 5, -5, 0, Q_MIN, 0, 0, 0, -1);
    issue_command(CMD_DIV, 3'd3, Q_MAX, -7, 32'h10000, 3, 1, 2, 32'h30000, -1);
    issue_command(CMD_DOT, 3'd4, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    issue_command(CMD_DOT, 3'd4, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    issue_command(CMD_DOT, 3'd2, -1, 3, 9, 9, 1, -5, 9, 9);
    issue_command(CMD_LENGTH, 3'd4, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
    issue_command(CMD_LENGTH, 3'd3, 32'h30000, 32'h40000, 0, 7, 0, 0, 0, 0);
    issue_command(CMD_NORM, 3'd4, 0, 0, 0, 0, 1, 1, 1, 1);
    issue_command(CMD_NORM, 3'd2, 1, 0, 9, 9, 0, 0, 0, 0);
    issue_command(CMD_NORM, 3'd4, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0);
    issue_command(CMD_CROSS, 3'd2, 32'h10000, 0, 0, 9, 0, 32'h10000, 0, 9);
    issue_command(CMD_CROSS, 3'd4, Q_MAX, Q_MIN, Q_MAX, 0, Q_MIN, Q_MAX, Q_MIN, 0);
    issue_command(CMD_ADD, 3'd0, 1, 2, 3, 4, 5, 6, 7, 8);
    issue_command(CMD_SUB, 3'd7, 1, 2, 3, 4, 5, 6, 7, 8);
    issue_command(CMD_MUL, 3'd1, -1, -1, -1, -1, -1, -1, -1, -1);
    pause_sender(1);
    while (pending != 0) @(posedge clk);

    while (sent < NUM_RANDOM + 18) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < NUM_RANDOM + 18) issue_random();
      end
      case ($urandom_range(0, 9))
        0: begin
          pause_sender(1);
          while (pending != 0) @(posedge clk);
        end
        1, 2, 3: ;
        default: pause_sender($urandom_range(1, 20));
      endcase
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d transactions over all commands and dims codes, checked %0d results.",
             sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
